FILE: design/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared widths, constants, controller states and the command/status
// structs between the subsample minimum finder controller and datapath.
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int COST_W   = 32;
	localparam int IDX_W    = 12;
	localparam int FRAC_W   = 8;
	localparam int POS_W    = 21;
	localparam int MAX_RUN  = 4096;

	localparam int DIFF_W   = COST_W;          // |L - R|
	localparam int DEN_W    = COST_W + 1;      // D = L + R - 2C
	localparam int PROD_W   = 2 * COST_W;      // (R - L)^2

	localparam int DIVD_W   = PROD_W;          // divider dividend
	localparam int DIVS_W   = DEN_W + 3;       // divider divisor (8D fits)
	localparam int DIV_CNT_W = $clog2(DIVD_W);

	localparam logic [COST_W-1:0] COST_SENTINEL = '1;
	localparam logic [IDX_W-1:0]  LAST_INDEX    = IDX_W'(MAX_RUN - 1);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_SEL,
		ST_MUL,
		ST_CSTART,
		ST_CORR,
		ST_FRAC,
		ST_FIN
	} smf_state_t;

	typedef struct packed {
		logic track;       // accept one cost item
		logic select;      // pick min, latch fit operands, clear run state
		logic mul;         // square the neighbour difference
		logic div_start;   // launch divider
		logic div_frac;    // divider operands: 0 = correction, 1 = fraction
		logic take_corr;   // capture correction quotient
		logic take_frac;   // capture fraction quotient
		logic load_out;    // load output register
	} smf_cmd_t;

	typedef struct packed {
		logic close;       // current item ends the run
		logic fit_ok;      // parabolic refinement applies
		logic div_done;    // divider result ready
	} smf_status_t;

endpackage

FILE: design/subsample_minimum_finder.sv
// After the closing item the controller runs selection, squaring and the output
// load; with refinement, two 64-step serial divisions come between and dominate.
// Throughput: one cost item per cycle inside a run; between runs the block
// takes no item from the closing item until the result is loaded.
// The output register lets the next run stream while a result waits.
// Reset (arst_n low): run state cleared, index_base = 0, no result pending.
// ----------------------------------------------------------------------------
// subsample_minimum_finder
// Streams a run of costs, finds the global (or interior local) minimum and
// refines its position and value with a parabolic fit through its neighbors.
// ----------------------------------------------------------------------------
module subsample_minimum_finder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [smf_pkg::IDX_W-1:0]        cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [smf_pkg::COST_W-1:0]       cost,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [smf_pkg::POS_W-1:0] position,
	output logic [smf_pkg::COST_W-1:0]       min_value,
	output logic                             used_local,
	output logic                             refined
);
	import smf_pkg::*;

	smf_cmd_t    cmd;
	smf_status_t status;

	smf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	smf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cost        (cost),
		.last        (last),
		.position    (position),
		.min_value   (min_value),
		.used_local  (used_local),
		.refined     (refined)
	);

endmodule

FILE: design/smf_divider.sv
// ----------------------------------------------------------------------------
// smf_divider
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// latches the operands; done pulses for one cycle when the quotient is valid.
// ----------------------------------------------------------------------------
module smf_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [smf_pkg::DIVD_W-1:0]  dividend,
	input  logic [smf_pkg::DIVS_W-1:0]  divisor,
	output logic                        done,
	output logic [smf_pkg::DIVD_W-1:0]  quotient
);
	import smf_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVS_W-1:0]     rem_q;
	logic [DIVS_W-1:0]     dvs_q;
	logic [DIVD_W-1:0]     quo_q;

	logic [DIVS_W:0]       trial;
	logic [DIVS_W:0]       trial_sub;
	logic                  fits;

	always_comb begin
		trial     = {rem_q, quo_q[DIVD_W-1]};
		trial_sub = trial - {1'b0, dvs_q};
		fits      = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: design/smf_datapath.sv
// ----------------------------------------------------------------------------
// smf_datapath
// Run tracking registers (global and interior local minimum with their
// neighbours), end-of-run selection, parabolic fit arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module smf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smf_pkg::smf_cmd_t             cmd,
	output smf_pkg::smf_status_t          status,
	input  logic                          cfg_wr_en,
	input  logic [smf_pkg::IDX_W-1:0]     cfg_wr_data,
	input  logic [smf_pkg::COST_W-1:0]    cost,
	input  logic                          last,
	output logic signed [smf_pkg::POS_W-1:0] position,
	output logic [smf_pkg::COST_W-1:0]    min_value,
	output logic                          used_local,
	output logic                          refined
);
	import smf_pkg::*;

	logic [IDX_W-1:0]   base_q;
	logic [IDX_W-1:0]   count_q;
	logic [COST_W-1:0]  prev_q, bprev_q;
	logic [COST_W-1:0]  gmin_q, gl_q, gr_q;
	logic [IDX_W-1:0]   gidx_q;
	logic [COST_W-1:0]  lmin_q, ll_q, lr_q;
	logic [IDX_W-1:0]   lidx_q;
	logic               lfound_q;

	// selection / fit registers
	logic [IDX_W-1:0]   sel_idx_q;
	logic [COST_W-1:0]  sel_val_q;
	logic               sel_local_q;
	logic               fit_q;
	logic               neg_q;
	logic [DEN_W-1:0]   den_q;
	logic [DIFF_W-1:0]  diff_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DIVD_W-1:0]  corr_q;
	logic [POS_W-1:0]   frac_q;

	// output register
	logic [POS_W-1:0]   pos_q;
	logic [COST_W-1:0]  val_q;
	logic               used_local_q;
	logic               refined_q;

	logic               is_close;
	logic               local_hit;

	logic               use_loc;
	logic [IDX_W-1:0]   s_idx;
	logic [COST_W-1:0]  s_val, s_l, s_r;
	logic               interior;
	logic               usable_lr;
	logic [DEN_W:0]     den_full;
	logic               fit_now;

	logic [DIVD_W-1:0]  div_dividend;
	logic [DIVS_W-1:0]  div_divisor;
	logic               div_done;
	logic [DIVD_W-1:0]  div_quo;

	logic [IDX_W-1:0]   abs_idx;
	logic [POS_W-1:0]   pos_int;
	logic [POS_W-1:0]   pos_fin;
	logic [COST_W-1:0]  val_fin;

	always_comb begin
		is_close  = last || (count_q == LAST_INDEX);
		local_hit = (count_q >= IDX_W'(2)) && (prev_q < bprev_q) && (prev_q < cost)
			&& (prev_q < lmin_q);
	end

	// end-of-run choice: an edge global minimum yields to an interior local one
	always_comb begin
		use_loc = ((gidx_q == '0) || (gidx_q == count_q)) && lfound_q;
		s_idx   = use_loc ? lidx_q : gidx_q;
		s_val   = use_loc ? lmin_q : gmin_q;
		s_l     = use_loc ? ll_q   : gl_q;
		s_r     = use_loc ? lr_q   : gr_q;
		interior  = (s_idx != '0) && (s_idx < count_q);
		usable_lr = (s_l != '0) && (s_l != COST_SENTINEL)
			&& (s_r != '0) && (s_r != COST_SENTINEL);
		den_full  = (DEN_W+1)'(s_l) + (DEN_W+1)'(s_r) - {1'b0, s_val, 1'b0};
		fit_now   = interior && usable_lr && !den_full[DEN_W] && (den_full != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			prev_q   <= '0;
			bprev_q  <= '0;
			gmin_q   <= '0;
			gidx_q   <= '0;
			gl_q     <= '0;
			gr_q     <= '0;
			lmin_q   <= COST_SENTINEL;
			lidx_q   <= '0;
			ll_q     <= '0;
			lr_q     <= '0;
			lfound_q <= 1'b0;
		end else if (cmd.select) begin
			count_q  <= '0;
			prev_q   <= '0;
			bprev_q  <= '0;
			gmin_q   <= '0;
			gidx_q   <= '0;
			gl_q     <= '0;
			gr_q     <= '0;
			lmin_q   <= COST_SENTINEL;
			lidx_q   <= '0;
			ll_q     <= '0;
			lr_q     <= '0;
			lfound_q <= 1'b0;
		end else if (cmd.track) begin
			if (count_q == '0) begin
				gmin_q <= cost;
				gidx_q <= '0;
			end else begin
				if (gidx_q == count_q - 1'b1)
					gr_q <= cost;
				if (cost < gmin_q) begin
					gmin_q <= cost;
					gidx_q <= count_q;
					gl_q   <= prev_q;
				end
				if (local_hit) begin
					lmin_q   <= prev_q;
					lidx_q   <= count_q - 1'b1;
					ll_q     <= bprev_q;
					lr_q     <= cost;
					lfound_q <= 1'b1;
				end
			end
			bprev_q <= prev_q;
			prev_q  <= cost;
			// on the closing item the count stays at the last index for selection
			if (!is_close)
				count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.select) begin
			sel_idx_q   <= s_idx;
			sel_val_q   <= s_val;
			sel_local_q <= use_loc;
			fit_q       <= fit_now;
			neg_q       <= s_r > s_l;
			den_q       <= den_full[DEN_W-1:0];
			diff_q      <= (s_l >= s_r) ? (s_l - s_r) : (s_r - s_l);
		end
		if (cmd.mul)
			prod_q <= PROD_W'(diff_q) * PROD_W'(diff_q);
		if (cmd.take_corr)
			corr_q <= div_quo;
		if (cmd.take_frac)
			frac_q <= div_quo[POS_W-1:0];
	end

	// correction: (R-L)^2 / 8D ; fraction: (diff*2^F + D) / 2D
	always_comb begin
		if (cmd.div_frac) begin
			div_dividend = DIVD_W'({diff_q, {FRAC_W{1'b0}}}) + DIVD_W'(den_q);
			div_divisor  = DIVS_W'({den_q, 1'b0});
		end else begin
			div_dividend = prod_q;
			div_divisor  = {den_q, 3'b000};
		end
	end

	smf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		abs_idx = base_q + sel_idx_q;
		pos_int = {1'b0, abs_idx, {FRAC_W{1'b0}}};
		if (!fit_q)
			pos_fin = pos_int;
		else if (neg_q)
			pos_fin = pos_int - frac_q;
		else
			pos_fin = pos_int + frac_q;
		if (!fit_q)
			val_fin = sel_val_q;
		else if (corr_q >= DIVD_W'(sel_val_q))
			val_fin = '0;
		else
			val_fin = sel_val_q - corr_q[COST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pos_q        <= pos_fin;
			val_q        <= val_fin;
			used_local_q <= sel_local_q;
			refined_q    <= fit_q;
		end
	end

	always_comb begin
		status.close    = is_close;
		status.fit_ok   = fit_q;
		status.div_done = div_done;
	end

	assign position   = pos_q;
	assign min_value  = val_q;
	assign used_local = used_local_q;
	assign refined    = refined_q;

endmodule

FILE: design/smf_ctrl.sv
// ----------------------------------------------------------------------------
// smf_ctrl
// Controller: streams a run in, then sequences selection, squaring, the two
// divisions (if the fit applies) and the output load; owns the input ready and output valid.
// ----------------------------------------------------------------------------
module smf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  smf_pkg::smf_status_t  status,
	output smf_pkg::smf_cmd_t     cmd
);
	import smf_pkg::*;

	smf_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.track = 1'b1;
					if (status.close)
						state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				cmd.select = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = status.fit_ok ? ST_CSTART : ST_FIN;
			end
			ST_CSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_CORR;
			end
			ST_CORR: begin
				if (status.div_done) begin
					cmd.take_corr = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_frac  = 1'b1;
					state_d       = ST_FRAC;
				end
			end
			ST_FRAC: begin
				cmd.div_frac = 1'b1;
				if (status.div_done) begin
					cmd.take_frac = 1'b1;
					state_d       = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/smf_checker.sv
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks for the subsample minimum finder, bound to the top level.
// ----------------------------------------------------------------------------
module smf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             last,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [smf_pkg::POS_W-1:0] position,
	input logic [smf_pkg::COST_W-1:0]       min_value,
	input logic                             used_local,
	input logic                             refined
);
	import smf_pkg::*;

	// a closing item always stalls the input for at least the selection cycle
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input ready right after closing item");

	// without refinement the position carries no fraction
	a_plain_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !refined |-> position[FRAC_W-1:0] == '0)
		else $error("fraction present on unrefined result");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(position) && $stable(min_value)
			&& $stable(used_local) && $stable(refined))
		else $error("result changed while stalled");

endmodule

bind subsample_minimum_finder smf_checker u_smf_checker (.*);
